// ===== rtl/core/tfda_pkg.sv =====
package tfda_pkg;

  typedef struct packed {
    logic [15:0] cell_value;
    logic        frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
    logic [3:0] byte_count;
    logic       last_of_run;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_CURSOR,
    S_NEXT,
    S_FETCH,
    S_COLOR,
    S_CHAR
  } state_t;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_THREE    = 8'h33;
  localparam logic [7:0] CH_FOUR     = 8'h34;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [6:0] CH_SPACE    = 7'h20;
  localparam logic [6:0] CH_DEL      = 7'h7F;
  localparam logic [3:0] DIGIT_HI    = 4'h3;

  localparam logic [3:0] LEN_ONE   = 4'd1;
  localparam logic [3:0] LEN_SHORT = 4'd5;
  localparam logic [3:0] LEN_FULL  = 4'd8;

  // VGA attribute color to ANSI color: reverse the three color bits, ignore intensity
  function automatic logic [2:0] vga_color(input logic [3:0] code);
    return {code[0], code[1], code[2]};
  endfunction

  function automatic logic [3:0] bcd_inc(input logic [3:0] digit);
    return (digit == 4'd9) ? 4'd0 : digit + 4'd1;
  endfunction

endpackage

// ===== rtl/core/text_frame_diff_to_ansi.sv =====
// Text frame differ: takes COLUMNS x ROWS text cells in raster order, compares each with the
// copy of the last frame held in an on-chip RAM and sends the ANSI byte groups that bring a
// terminal up to date (cursor move, replayed cells, color changes, characters), one group of
// up to eight bytes per output transfer. The single RAM read port and the output register set
// the pace: a cell is finished before the next is taken, and a changed cell costs more than an
// unchanged one for the cursor move, each replayed cell and each cell sent, plus any output
// stall. After reset the RAM is zeroed one entry per cycle, and in_ready stays low until all
// COLUMNS*ROWS entries (2000 by default) are cleared.
module text_frame_diff_to_ansi #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int MAX_GAP = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tfda_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tfda_pkg::out_t  out_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int POS_W  = $clog2(CELLS + 1);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  tfda_pkg::state_t state, state_next;

  logic [ADDR_W-1:0] clr_addr;
  logic [POS_W-1:0]  cell_position;
  logic [POS_W-1:0]  run_start;
  logic              position_unknown;
  logic [5:0]        current_colors;
  logic              colors_known;
  logic [COL_W-1:0]  col_index;
  logic [3:0]        row_tens, row_ones, col_tens, col_ones;
  logic [15:0]       cell_in;
  logic [15:0]       cur_cell;
  logic              final_cell;
  logic [POS_W-1:0]  pos;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;

  logic              accept, in_range, clr_last, differs, need_cursor, more, out_free;
  logic [POS_W-1:0]  index_eff, gap;
  logic [2:0]        fg, bg;
  logic [5:0]        colors_now;
  logic              need_color, fg_diff, bg_diff;
  logic              emit_cursor, emit_color, emit_char, emit, advance;
  logic [6:0]        ch7;
  logic [7:0]        ch;
  tfda_pkg::out_t    cursor_grp, color_grp, char_grp, grp;

  tfda_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept      = in_valid & in_ready;
  assign index_eff   = in_data.frame_start ? '0 : cell_position;
  assign in_range    = index_eff < POS_W'(CELLS);
  assign clr_last    = clr_addr == ADDR_W'(CELLS - 1);
  assign differs     = ram_rdata != cell_in;
  assign gap         = cell_position - run_start;
  assign need_cursor = position_unknown | (32'(gap) > 32'(MAX_GAP));
  assign more        = pos < cell_position;
  assign out_free    = ~out_valid | out_ready;

  assign fg         = tfda_pkg::vga_color(cur_cell[11:8]);
  assign bg         = tfda_pkg::vga_color(cur_cell[15:12]);
  assign colors_now = {bg, fg};
  assign need_color = ~colors_known | (current_colors != colors_now);
  assign fg_diff    = ~colors_known | (current_colors[2:0] != fg);
  assign bg_diff    = ~colors_known | (current_colors[5:3] != bg);

  assign ch7 = cur_cell[6:0];
  assign ch  = (ch7 < tfda_pkg::CH_SPACE || ch7 == tfda_pkg::CH_DEL) ?
               tfda_pkg::CH_QUEST : {1'b0, ch7};

  always_comb begin
    state_next = state;
    unique case (state)
      tfda_pkg::S_CLEAR:  if (clr_last) state_next = tfda_pkg::S_IDLE;
      tfda_pkg::S_IDLE:   if (accept && in_range) state_next = tfda_pkg::S_LOOK;
      tfda_pkg::S_LOOK: begin
        if (!differs) state_next = tfda_pkg::S_IDLE;
        else if (need_cursor) state_next = tfda_pkg::S_CURSOR;
        else state_next = tfda_pkg::S_NEXT;
      end
      tfda_pkg::S_CURSOR: if (out_free) state_next = tfda_pkg::S_NEXT;
      tfda_pkg::S_NEXT:   state_next = more ? tfda_pkg::S_FETCH : tfda_pkg::S_COLOR;
      tfda_pkg::S_FETCH:  state_next = tfda_pkg::S_COLOR;
      tfda_pkg::S_COLOR:  if (!need_color || out_free) state_next = tfda_pkg::S_CHAR;
      tfda_pkg::S_CHAR: begin
        if (out_free) state_next = final_cell ? tfda_pkg::S_IDLE : tfda_pkg::S_NEXT;
      end
      default:            state_next = tfda_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = state == tfda_pkg::S_IDLE;
    emit_cursor = (state == tfda_pkg::S_CURSOR) & out_free;
    emit_color  = (state == tfda_pkg::S_COLOR) & need_color & out_free;
    emit_char   = (state == tfda_pkg::S_CHAR) & out_free;
    emit        = emit_cursor | emit_color | emit_char;
    advance     = ((state == tfda_pkg::S_LOOK) & ~differs) | (emit_char & final_cell);
    ram_raddr   = (state == tfda_pkg::S_IDLE) ? index_eff[ADDR_W-1:0] : pos[ADDR_W-1:0];
    ram_we      = (state == tfda_pkg::S_CLEAR) | (emit_char & final_cell);
    ram_waddr   = (state == tfda_pkg::S_CLEAR) ? clr_addr : cell_position[ADDR_W-1:0];
    ram_wdata   = (state == tfda_pkg::S_CLEAR) ? '0 : cell_in;
  end

  always_comb begin
    cursor_grp             = '0;
    cursor_grp.byte0       = tfda_pkg::CH_ESC;
    cursor_grp.byte1       = tfda_pkg::CH_LBRACKET;
    cursor_grp.byte2       = {tfda_pkg::DIGIT_HI, row_tens};
    cursor_grp.byte3       = {tfda_pkg::DIGIT_HI, row_ones};
    if (col_index != '0) begin
      cursor_grp.byte4      = tfda_pkg::CH_SEMI;
      cursor_grp.byte5      = {tfda_pkg::DIGIT_HI, col_tens};
      cursor_grp.byte6      = {tfda_pkg::DIGIT_HI, col_ones};
      cursor_grp.byte7      = tfda_pkg::CH_H;
      cursor_grp.byte_count = tfda_pkg::LEN_FULL;
    end else begin
      cursor_grp.byte4      = tfda_pkg::CH_H;
      cursor_grp.byte_count = tfda_pkg::LEN_SHORT;
    end

    color_grp       = '0;
    color_grp.byte0 = tfda_pkg::CH_ESC;
    color_grp.byte1 = tfda_pkg::CH_LBRACKET;
    if (fg_diff && bg_diff) begin
      color_grp.byte2      = tfda_pkg::CH_THREE;
      color_grp.byte3      = {5'b00110, fg};
      color_grp.byte4      = tfda_pkg::CH_SEMI;
      color_grp.byte5      = tfda_pkg::CH_FOUR;
      color_grp.byte6      = {5'b00110, bg};
      color_grp.byte7      = tfda_pkg::CH_M;
      color_grp.byte_count = tfda_pkg::LEN_FULL;
    end else begin
      color_grp.byte2      = fg_diff ? tfda_pkg::CH_THREE : tfda_pkg::CH_FOUR;
      color_grp.byte3      = {5'b00110, (fg_diff ? fg : bg)};
      color_grp.byte4      = tfda_pkg::CH_M;
      color_grp.byte_count = tfda_pkg::LEN_SHORT;
    end

    char_grp             = '0;
    char_grp.byte0       = ch;
    char_grp.byte_count  = tfda_pkg::LEN_ONE;
    char_grp.last_of_run = final_cell;

    unique case (state)
      tfda_pkg::S_CURSOR: grp = cursor_grp;
      tfda_pkg::S_COLOR:  grp = color_grp;
      default:            grp = char_grp;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= tfda_pkg::S_CLEAR;
      clr_addr         <= '0;
      cell_position    <= '0;
      run_start        <= '0;
      position_unknown <= 1'b1;
      current_colors   <= '0;
      colors_known     <= 1'b0;
      col_index        <= '0;
      row_tens         <= 4'd0;
      row_ones         <= 4'd1;
      col_tens         <= 4'd0;
      col_ones         <= 4'd1;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tfda_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept && in_data.frame_start) begin
        cell_position    <= '0;
        run_start        <= '0;
        position_unknown <= 1'b1;
        colors_known     <= 1'b0;
        col_index        <= '0;
        row_tens         <= 4'd0;
        row_ones         <= 4'd1;
        col_tens         <= 4'd0;
        col_ones         <= 4'd1;
      end
      if (emit_cursor) begin
        run_start        <= cell_position;
        position_unknown <= 1'b0;
      end
      if (emit_color) begin
        current_colors <= colors_now;
        colors_known   <= 1'b1;
      end
      if (emit_char && final_cell) begin
        run_start <= cell_position + 1'b1;
      end
      if (advance) begin
        cell_position <= cell_position + 1'b1;
        if (col_index == COL_W'(COLUMNS - 1)) begin
          col_index <= '0;
          col_tens  <= 4'd0;
          col_ones  <= 4'd1;
          row_ones  <= tfda_pkg::bcd_inc(row_ones);
          if (row_ones == 4'd9) row_tens <= tfda_pkg::bcd_inc(row_tens);
        end else begin
          col_index <= col_index + 1'b1;
          col_ones  <= tfda_pkg::bcd_inc(col_ones);
          if (col_ones == 4'd9) col_tens <= tfda_pkg::bcd_inc(col_tens);
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_in <= in_data.cell_value;
    end
    if (state == tfda_pkg::S_LOOK) begin
      pos <= run_start;
    end
    if (emit_cursor) begin
      pos <= cell_position;
    end
    if (state == tfda_pkg::S_NEXT && !more) begin
      cur_cell   <= cell_in;
      final_cell <= 1'b1;
    end
    if (state == tfda_pkg::S_FETCH) begin
      cur_cell   <= ram_rdata;
      final_cell <= 1'b0;
    end
    if (emit_char && !final_cell) begin
      pos <= pos + 1'b1;
    end
    if (emit) begin
      out_data <= grp;
    end
  end

endmodule

// ===== rtl/core/tfda_ram.sv =====
module tfda_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tfda_checker.sv =====
module tfda_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input tfda_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transfer changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.byte_count == tfda_pkg::LEN_ONE ||
                  out_data.byte_count == tfda_pkg::LEN_SHORT ||
                  out_data.byte_count == tfda_pkg::LEN_FULL)
    else $error("group length is not 1, 5 or 8");

  a_seq_escape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_count != tfda_pkg::LEN_ONE |->
      out_data.byte0 == tfda_pkg::CH_ESC && !out_data.last_of_run)
    else $error("escape group malformed or closes a run");

  a_char_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_count == tfda_pkg::LEN_ONE |->
      out_data.byte0 >= 8'h20 && out_data.byte0 <= 8'h7E && out_data.byte1 == 8'h00)
    else $error("character group not printable");

endmodule

bind text_frame_diff_to_ansi tfda_checker u_tfda_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/text_frame_diff_to_ansi_tb.sv =====
module text_frame_diff_to_ansi_tb;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int MAX_GAP = 8;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_ITEMS = 40;
  localparam int DIR_ROWS = 24;
  localparam logic [7:0] KEY_ESC = 8'h1B;

  typedef struct {
    bit          new_frame;
    logic [15:0] word;
    string       want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tfda_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tfda_pkg::out_t out_data;

  text_frame_diff_to_ansi #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS),
    .MAX_GAP(MAX_GAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // terminal image as the block should hold it
  logic [15:0] frame_copy [0:CELLS-1];
  int          next_index;
  int          run_from;
  bit          cursor_lost;
  logic [5:0]  shown_colors;
  bit          colors_valid;

  logic [7:0]  group_bytes [0:7];
  int          group_len;
  tfda_pkg::out_t step_groups [$];
  tfda_pkg::out_t awaited_groups [$];

  // stimulus, built before reset
  tfda_pkg::in_t cells_to_send [$];
  string       typed_want [$];
  bit          drain_before [$];
  logic [15:0] gen_frame [0:CELLS-1];
  int          gen_pos;
  logic [7:0]  last_attr;
  row_t        dir_rows [DIR_ROWS];

  int accepted;
  int fails;
  int cycle_count;
  bit hold_req;
  bit hold_done;
  bit calm;

  function automatic logic [2:0] ansi_hue(input logic [3:0] vga);
    case (vga[2:0])
      3'd0: return 3'd0;
      3'd1: return 3'd4;
      3'd2: return 3'd2;
      3'd3: return 3'd6;
      3'd4: return 3'd1;
      3'd5: return 3'd5;
      3'd6: return 3'd3;
      default: return 3'd7;
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    group_bytes[group_len] = b;
    group_len++;
  endfunction

  function automatic void close_group();
    tfda_pkg::out_t g;
    int   j;
    for (j = group_len; j < 8; j++) group_bytes[j] = 8'h00;
    g.byte0 = group_bytes[0];
    g.byte1 = group_bytes[1];
    g.byte2 = group_bytes[2];
    g.byte3 = group_bytes[3];
    g.byte4 = group_bytes[4];
    g.byte5 = group_bytes[5];
    g.byte6 = group_bytes[6];
    g.byte7 = group_bytes[7];
    g.byte_count = 4'(group_len);
    g.last_of_run = 1'b0;
    step_groups.push_back(g);
    group_len = 0;
  endfunction

  function automatic void mark_last();
    tfda_pkg::out_t g;
    if (step_groups.size() > 0) begin
      g = step_groups.pop_back();
      g.last_of_run = 1'b1;
      step_groups.push_back(g);
    end
  endfunction

  function automatic void paint_cell(input logic [15:0] word);
    logic [2:0] fg;
    logic [2:0] bg;
    logic [5:0] pair;
    logic [7:0] ch;
    bit         fg_diff;
    bit         bg_diff;
    fg = ansi_hue(word[11:8]);
    bg = ansi_hue(word[15:12]);
    pair = {bg, fg};
    if (!colors_valid || shown_colors != pair) begin
      fg_diff = !colors_valid || shown_colors[2:0] != fg;
      bg_diff = !colors_valid || shown_colors[5:3] != bg;
      add_byte(KEY_ESC);
      add_byte("[");
      if (fg_diff) begin
        add_byte("3");
        add_byte(8'h30 + {5'd0, fg});
      end
      if (fg_diff && bg_diff) add_byte(";");
      if (bg_diff) begin
        add_byte("4");
        add_byte(8'h30 + {5'd0, bg});
      end
      add_byte("m");
      close_group();
      shown_colors = pair;
      colors_valid = 1'b1;
    end
    ch = {1'b0, word[6:0]};
    if (ch < 8'd32 || ch > 8'd126) ch = "?";
    add_byte(ch);
    close_group();
  endfunction

  function automatic void ansi_for_cell(input tfda_pkg::in_t item);
    int idx;
    int line;
    int col;
    int p;
    step_groups.delete();
    group_len = 0;
    if (item.frame_start) begin
      next_index = 0;
      run_from = 0;
      cursor_lost = 1'b1;
      colors_valid = 1'b0;
    end
    if (next_index >= CELLS) return;
    idx = next_index;
    next_index = idx + 1;
    if (frame_copy[idx] == item.cell_value) return;
    if (cursor_lost || idx - run_from > MAX_GAP) begin
      line = idx / COLUMNS + 1;
      col = idx % COLUMNS + 1;
      add_byte(KEY_ESC);
      add_byte("[");
      add_byte(8'(48 + (line / 10) % 10));
      add_byte(8'(48 + line % 10));
      if (col > 1) begin
        add_byte(";");
        add_byte(8'(48 + (col / 10) % 10));
        add_byte(8'(48 + col % 10));
      end
      add_byte("H");
      close_group();
      run_from = idx;
      cursor_lost = 1'b0;
    end
    for (p = run_from; p < idx; p++) paint_cell(frame_copy[p]);
    paint_cell(item.cell_value);
    frame_copy[idx] = item.cell_value;
    run_from = idx + 1;
    mark_last();
  endfunction

  // '^' stands for ESC, '|' closes a group
  function automatic void typed_groups(input string s);
    logic [7:0] c;
    int         i;
    step_groups.delete();
    group_len = 0;
    for (i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c == "|") close_group();
      else if (c == "^") add_byte(KEY_ESC);
      else add_byte(c);
    end
    if (s.len() > 0) begin
      close_group();
      mark_last();
    end
  endfunction

  function automatic string field_diffs(input tfda_pkg::out_t got,
                                        input tfda_pkg::out_t want);
    string s;
    s = "";
    if (got.byte0 !== want.byte0) s = {s, " byte0"};
    if (got.byte1 !== want.byte1) s = {s, " byte1"};
    if (got.byte2 !== want.byte2) s = {s, " byte2"};
    if (got.byte3 !== want.byte3) s = {s, " byte3"};
    if (got.byte4 !== want.byte4) s = {s, " byte4"};
    if (got.byte5 !== want.byte5) s = {s, " byte5"};
    if (got.byte6 !== want.byte6) s = {s, " byte6"};
    if (got.byte7 !== want.byte7) s = {s, " byte7"};
    if (got.byte_count !== want.byte_count) s = {s, " byte_count"};
    if (got.last_of_run !== want.last_of_run) s = {s, " last_of_run"};
    return s;
  endfunction

  function automatic void note_failure(input string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endfunction

  function automatic void queue_cell(input bit fs, input logic [15:0] word, input string want,
                                     input bit drain);
    tfda_pkg::in_t x;
    x.cell_value = word;
    x.frame_start = fs;
    cells_to_send.push_back(x);
    typed_want.push_back(want);
    drain_before.push_back(drain);
    if (fs) gen_pos = 0;
    if (gen_pos < CELLS) begin
      gen_frame[gen_pos] = word;
      gen_pos++;
    end
  endfunction

  function automatic logic [15:0] fresh_cell();
    logic [7:0] attr;
    logic [7:0] ch;
    attr = ($urandom_range(0, 9) < 3) ? last_attr : 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 9))
        0: ch = 8'h00;
        1: ch = 8'h1F;
        2: ch = 8'h20;
        3: ch = 8'h7E;
        4: ch = 8'h7F;
        5: ch = 8'h80;
        6: ch = 8'h9F;
        7: ch = 8'hA0;
        8: ch = 8'hFE;
        default: ch = 8'hFF;
      endcase
    end else begin
      ch = 8'($urandom);
    end
    last_attr = attr;
    return {attr, ch};
  endfunction

  function automatic logic [15:0] stored_cell(input bit fs);
    int p;
    p = fs ? 0 : gen_pos;
    return (p < CELLS) ? gen_frame[p] : 16'($urandom);
  endfunction

  // unchanged stretches of 0 to 12 cells around changed ones cross the gap limit both ways
  function automatic void queue_segment(input bit fs_first, input int changes);
    int k;
    int r;
    int n;
    bit fs;
    fs = fs_first;
    for (k = 0; k < changes; k++) begin
      n = $urandom_range(0, 12);
      for (r = 0; r < n; r++) begin
        queue_cell(fs, stored_cell(fs), "*", 1'b0);
        fs = 1'b0;
      end
      queue_cell(fs, fresh_cell(), "*", $urandom_range(0, 39) == 0);
      fs = 1'b0;
    end
  endfunction

  function automatic void queue_random_burst();
    int n;
    int k;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: queue_segment(1'b1, $urandom_range(1, 6));
      14, 15, 16: queue_segment(1'b0, $urandom_range(1, 4));
      default: begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          queue_cell($urandom_range(0, 3) == 0, 16'($urandom), "*", 1'b0);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    tfda_pkg::out_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        ansi_for_cell(in_data);
        if (typed_want[accepted] != "*") typed_groups(typed_want[accepted]);
        foreach (step_groups[k]) awaited_groups.push_back(step_groups[k]);
        accepted++;
      end
      if (out_valid && out_ready) begin
        if (awaited_groups.size() == 0) begin
          note_failure($sformatf("unexpected group %h", out_data));
        end else begin
          want = awaited_groups.pop_front();
          if (out_data !== want) begin
            note_failure($sformatf("group mismatch in%s: expected %h actual %h",
                                   field_diffs(out_data, want), want, out_data));
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int span;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        case ($urandom_range(0, 7))
          0: begin
            out_ready <= 1'b1;
            span = $urandom_range(40, 120);
          end
          1, 2: begin
            out_ready <= 1'b0;
            span = $urandom_range(1, 16);
          end
          default: begin
            out_ready <= 1'b1;
            span = $urandom_range(1, 16);
          end
        endcase
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin
    int i;
    int p;
    int calm_from;
    int quiet_pct;
    int random_a_end;
    int random_b_end;

    dir_rows = '{
      '{1'b1, 16'h0000, ""},
      '{1'b0, 16'h0741, "^[01;02H|^[37;40m|A"},
      '{1'b0, 16'hFFFF, "^[47m|?"},
      '{1'b0, 16'h771F, "?"},
      '{1'b0, 16'h7720, " "},
      '{1'b0, 16'h777E, "~"},
      '{1'b0, 16'h7780, "?"},
      '{1'b0, 16'h77FE, "~"},
      '{1'b0, 16'h1200, "^[32;44m|?"},
      '{1'b0, 16'h0000, ""},
      '{1'b0, 16'h0000, ""},
      '{1'b0, 16'h0000, ""},
      '{1'b0, 16'h0000, ""},
      '{1'b0, 16'h0000, ""},
      '{1'b0, 16'h0000, ""},
      '{1'b0, 16'h0000, ""},
      '{1'b0, 16'h0000, ""},
      '{1'b0, 16'h5A61, "*"},
      '{1'b1, 16'h0741, "^[01H|^[37;40m|A"},
      '{1'b0, 16'h0741, ""},
      '{1'b0, 16'h0742, "A|B"},
      '{1'b0, 16'h0F42, "B"},
      '{1'b0, 16'h8742, "B"},
      '{1'b0, 16'h0142, "^[34m|B"}
    };

    for (p = 0; p < CELLS; p++) begin
      frame_copy[p] = 16'h0000;
      gen_frame[p] = 16'h0000;
    end
    next_index = 0;
    run_from = 0;
    cursor_lost = 1'b1;
    shown_colors = 6'd0;
    colors_valid = 1'b0;
    gen_pos = 0;
    last_attr = 8'h07;

    for (i = 0; i < DIR_ROWS; i++) begin
      queue_cell(dir_rows[i].new_frame, dir_rows[i].word, dir_rows[i].want, 1'b0);
    end
    queue_cell(1'b1, fresh_cell(), "*", 1'b1);
    random_a_end = cells_to_send.size() + 80;
    while (cells_to_send.size() < random_a_end) queue_random_burst();

    random_b_end = cells_to_send.size() + 75;
    queue_segment(1'b1, 2);
    while (cells_to_send.size() < random_b_end) queue_random_burst();
    calm_from = cells_to_send.size() - CALM_ITEMS;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    quiet_pct = 0;
    for (i = 0; i < cells_to_send.size(); i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(0, 2))
          0: quiet_pct = 0;
          1: quiet_pct = 25;
          default: quiet_pct = 60;
        endcase
      end
      if (i == DIR_ROWS + 8) hold_req = 1'b1;
      if (i >= calm_from) calm = 1'b1;
      if (drain_before[i]) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_groups.size() != 0 || accepted != i) @(posedge clk);
      end
      if (!calm && $urandom_range(1, 100) <= quiet_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= cells_to_send[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (awaited_groups.size() != 0 || accepted != cells_to_send.size()) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
